// ----- hw/rtl/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants and types for the CAN signal extract and scale block.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int DEF_MAX_FIELD_BITS = 32;
    localparam int MAX_PAYLOAD_BYTES  = 8;
    localparam int PAYLOAD_BITS       = 64;
    localparam int DIV_BITS           = 16;
    localparam int SCALED_BITS        = 49;

    typedef enum logic [2:0] {
        REG_START_BIT        = 3'd0,
        REG_FIELD_LENGTH     = 3'd1,
        REG_BIG_ENDIAN       = 3'd2,
        REG_SCALE_MULTIPLIER = 3'd3,
        REG_SCALE_DIVIDER    = 3'd4,
        REG_RAW_OFFSET       = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic err;
        logic neg;
    } t_meta;

endpackage

// ----- hw/rtl/cse_extract.sv -----
// ----------------------------------------------------------------------------
// cse_extract
// Cuts the configured field out of the payload, reorders little-endian
// chunks and flags fields that run past the valid bytes. One register stage.
// ----------------------------------------------------------------------------
module cse_extract
    import cse_pkg::*;
#(
    parameter int FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [3:0]              i_byte_count,
    input  logic [5:0]              i_start_bit,
    input  logic [5:0]              i_field_length,
    input  logic                    i_big_endian,
    output logic                    o_valid,
    output logic                    o_err,
    output logic [FIELD_BITS-1:0]   o_raw
);

    localparam int NUM_BYTES = (FIELD_BITS + 7) / 8;

    logic [5:0]              n_len;
    logic [3:0]              n_bc;
    logic                    n_err;
    logic [PAYLOAD_BITS-1:0] n_win;
    logic [PAYLOAD_BITS-1:0] n_be;
    logic [8*NUM_BYTES-1:0]  n_le;
    logic [FIELD_BITS-1:0]   n_raw;

    logic                    r_valid;
    logic                    r_err;
    logic [FIELD_BITS-1:0]   r_raw;

    always_comb begin
        n_len = (i_field_length > 6'(FIELD_BITS)) ? 6'(FIELD_BITS) : i_field_length;
        n_bc  = (i_byte_count > 4'(MAX_PAYLOAD_BYTES)) ? 4'(MAX_PAYLOAD_BYTES) : i_byte_count;
        n_err = ({1'b0, i_start_bit} + {1'b0, n_len}) > {n_bc, 3'b000};
        // field msb aligned to bit 63
        n_win = i_payload << i_start_bit;
        n_be  = n_win >> (7'd64 - {1'b0, n_len});
        n_le  = '0;
        for (int k = 0; k < NUM_BYTES; k++) begin
            if ({1'b0, n_len} >= 7'(8 * k + 8)) begin
                n_le[8*k +: 8] = n_win[PAYLOAD_BITS-1-8*k -: 8];
            end else if ({1'b0, n_len} > 7'(8 * k)) begin
                // partial last chunk, right aligned
                n_le[8*k +: 8] = n_win[PAYLOAD_BITS-1-8*k -: 8] >> (4'd8 - {1'b0, n_len[2:0]});
            end
        end
        if (n_err || n_len == '0) begin
            n_raw = '0;
        end else if (i_big_endian) begin
            n_raw = n_be[FIELD_BITS-1:0];
        end else begin
            n_raw = n_le[FIELD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err <= n_err;
            r_raw <= n_raw;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_raw   = r_raw;

endmodule

// ----- hw/rtl/cse_mul.sv -----
// ----------------------------------------------------------------------------
// cse_mul
// Adds the offset, splits into sign and magnitude and multiplies the
// magnitudes. Two register stages.
// ----------------------------------------------------------------------------
module cse_mul
    import cse_pkg::*;
#(
    parameter int FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_en,
    input  logic                                                  i_valid,
    input  logic                                                  i_err,
    input  logic [FIELD_BITS-1:0]                                 i_raw,
    input  logic signed [DIV_BITS-1:0]                            i_multiplier,
    input  logic signed [DIV_BITS-1:0]                            i_offset,
    output logic                                                  o_valid,
    output t_meta                                                 o_meta,
    output logic [FIELD_BITS-1:0]                                 o_raw,
    output logic [((FIELD_BITS > DIV_BITS) ? FIELD_BITS : DIV_BITS)+1+DIV_BITS-1:0] o_prod
);

    localparam int SUM_BITS  = ((FIELD_BITS > DIV_BITS) ? FIELD_BITS : DIV_BITS) + 2;
    localparam int MAG_BITS  = SUM_BITS - 1;
    localparam int PROD_BITS = MAG_BITS + DIV_BITS;

    logic [SUM_BITS-1:0]   n_sum;
    logic [SUM_BITS-1:0]   n_sum_abs;
    logic [DIV_BITS-1:0]   n_mul_abs;
    t_meta                 n_meta;
    logic [PROD_BITS-1:0]  n_prod;

    logic                  r_p_valid;
    t_meta                 r_p_meta;
    logic [FIELD_BITS-1:0] r_p_raw;
    logic [MAG_BITS-1:0]   r_p_msum;
    logic [DIV_BITS-1:0]   r_p_mmul;

    logic                  r_m_valid;
    t_meta                 r_m_meta;
    logic [FIELD_BITS-1:0] r_m_raw;
    logic [PROD_BITS-1:0]  r_m_prod;

    always_comb begin
        n_sum = {{(SUM_BITS-FIELD_BITS){1'b0}}, i_raw}
              + {{(SUM_BITS-DIV_BITS){i_offset[DIV_BITS-1]}}, i_offset};
        n_sum_abs = n_sum[SUM_BITS-1] ? (SUM_BITS'(0) - n_sum) : n_sum;
        n_mul_abs = i_multiplier[DIV_BITS-1] ? (DIV_BITS'(0) - i_multiplier) : i_multiplier;
        n_meta.err = i_err;
        n_meta.neg = n_sum[SUM_BITS-1] ^ i_multiplier[DIV_BITS-1];
        n_prod = PROD_BITS'(r_p_msum) * PROD_BITS'(r_p_mmul);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_m_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_meta <= n_meta;
            r_p_raw  <= i_raw;
            r_p_msum <= n_sum_abs[MAG_BITS-1:0];
            r_p_mmul <= n_mul_abs;
            r_m_meta <= r_p_meta;
            r_m_raw  <= r_p_raw;
            r_m_prod <= n_prod;
        end
    end

    assign o_valid = r_m_valid;
    assign o_meta  = r_m_meta;
    assign o_raw   = r_m_raw;
    assign o_prod  = r_m_prod;

endmodule

// ----- hw/rtl/cse_div_cell.sv -----
// ----------------------------------------------------------------------------
// cse_div_cell
// One cell of the divider chain: develops one quotient bit by restoring
// compare and subtract, and hands its partial result to the next cell.
// ----------------------------------------------------------------------------
module cse_div_cell
    import cse_pkg::*;
#(
    parameter int RAW_BITS  = DEF_MAX_FIELD_BITS,
    parameter int PROD_BITS = 49
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [DIV_BITS-1:0]  i_div,
    input  logic                 i_valid,
    input  t_meta                i_meta,
    input  logic [RAW_BITS-1:0]  i_raw,
    input  logic [DIV_BITS-1:0]  i_rem,
    input  logic [PROD_BITS-1:0] i_dq,
    output logic                 o_valid,
    output t_meta                o_meta,
    output logic [RAW_BITS-1:0]  o_raw,
    output logic [DIV_BITS-1:0]  o_rem,
    output logic [PROD_BITS-1:0] o_dq
);

    logic [DIV_BITS:0]    n_trial;
    logic                 n_qbit;
    logic [DIV_BITS:0]    n_diff;
    logic [DIV_BITS-1:0]  n_rem;
    logic [PROD_BITS-1:0] n_dq;

    logic                 r_valid;
    t_meta                r_meta;
    logic [RAW_BITS-1:0]  r_raw;
    logic [DIV_BITS-1:0]  r_rem;
    logic [PROD_BITS-1:0] r_dq;

    always_comb begin
        n_trial = {i_rem, i_dq[PROD_BITS-1]};
        n_qbit  = n_trial >= {1'b0, i_div};
        n_diff  = n_trial - {1'b0, i_div};
        n_rem   = n_qbit ? n_diff[DIV_BITS-1:0] : n_trial[DIV_BITS-1:0];
        // dividend bits shift out at the top, quotient bits in at the bottom
        n_dq    = {i_dq[PROD_BITS-2:0], n_qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta <= i_meta;
            r_raw  <= i_raw;
            r_rem  <= n_rem;
            r_dq   <= n_dq;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_raw   = r_raw;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;

endmodule

// ----- hw/rtl/can_signal_extract_scale.sv -----
// ----------------------------------------------------------------------------
// can_signal_extract_scale
// Extracts one signal from a CAN frame payload and scales it linearly.
// ----------------------------------------------------------------------------
// Takes one frame per clock unless stalled and returns one result per frame,
// in order. A frame goes through an extract stage, two offset and multiply
// stages, a chain of divider cells (one quotient bit per cell, 2*DIV_BITS+1
// cells for fields of 16 bits or less, else MAX_FIELD_BITS+DIV_BITS+1, 49 at
// the default) and an output register. The divider chain sets the latency;
// throughput is one frame per cycle as long as the output is taken. When the
// output stalls, a skid register takes the last result and the whole chain
// then holds until it drains. Registers must be written through the APB port
// only while no frame is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module can_signal_extract_scale
    import cse_pkg::*;
#(
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // payload[63:0], byte_count[67:64], zero
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // raw_value[31:0], scaled_value[80:32], zero
    output logic        m_tuser,   // range_error
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MAG_BITS  = ((MAX_FIELD_BITS > DIV_BITS) ? MAX_FIELD_BITS : DIV_BITS) + 1;
    localparam int PROD_BITS = MAG_BITS + DIV_BITS;
    localparam int EXT_BITS  = (PROD_BITS > SCALED_BITS) ? PROD_BITS + 1 : SCALED_BITS + 1;

    // configuration registers
    logic [5:0]                 r_start_bit;
    logic [5:0]                 r_field_length;
    logic                       r_big_endian;
    logic [DIV_BITS-1:0]        r_scale_multiplier;
    logic [DIV_BITS-1:0]        r_scale_divider;
    logic [DIV_BITS-1:0]        r_raw_offset;
    t_reg_idx                   w_reg_idx;
    logic                       w_cfg_wr;
    logic [DIV_BITS-1:0]        w_div;

    // pipeline
    logic                       w_en;
    logic                       w_ext_valid;
    logic                       w_ext_err;
    logic [MAX_FIELD_BITS-1:0]  w_ext_raw;
    logic                       w_valid [0:PROD_BITS];
    t_meta                      w_meta  [0:PROD_BITS];
    logic [MAX_FIELD_BITS-1:0]  w_raw   [0:PROD_BITS];
    logic [DIV_BITS-1:0]        w_rem   [0:PROD_BITS];
    logic [PROD_BITS-1:0]       w_dq    [0:PROD_BITS];

    // output stage
    logic                       w_push;
    logic [EXT_BITS-1:0]        n_q;
    logic [EXT_BITS-1:0]        n_lim;
    logic [EXT_BITS-1:0]        n_mag;
    logic [EXT_BITS-1:0]        n_signed;
    logic [SCALED_BITS-1:0]     n_scaled;
    logic [87:0]                n_data;
    logic                       n_err;
    logic                       r_out_valid;
    logic [87:0]                r_out_data;
    logic                       r_out_err;
    logic                       r_skid_valid;
    logic [87:0]                r_skid_data;
    logic                       r_skid_err;

    // ------------------------------------------------------------------
    // apb registers
    // ------------------------------------------------------------------
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bit        <= '0;
            r_field_length     <= '0;
            r_big_endian       <= 1'b0;
            r_scale_multiplier <= DIV_BITS'(1);
            r_scale_divider    <= DIV_BITS'(1);
            r_raw_offset       <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_START_BIT:        r_start_bit        <= pwdata[5:0];
                REG_FIELD_LENGTH:     r_field_length     <= pwdata[5:0];
                REG_BIG_ENDIAN:       r_big_endian       <= pwdata[0];
                REG_SCALE_MULTIPLIER: r_scale_multiplier <= pwdata[DIV_BITS-1:0];
                REG_SCALE_DIVIDER:    r_scale_divider    <= pwdata[DIV_BITS-1:0];
                REG_RAW_OFFSET:       r_raw_offset       <= pwdata[DIV_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_START_BIT:        prdata = {26'b0, r_start_bit};
            REG_FIELD_LENGTH:     prdata = {26'b0, r_field_length};
            REG_BIG_ENDIAN:       prdata = {31'b0, r_big_endian};
            REG_SCALE_MULTIPLIER: prdata = {16'b0, r_scale_multiplier};
            REG_SCALE_DIVIDER:    prdata = {16'b0, r_scale_divider};
            REG_RAW_OFFSET:       prdata = {16'b0, r_raw_offset};
            default:              prdata = '0;
        endcase
    end

    // zero divider acts as one
    assign w_div = (r_scale_divider == '0) ? DIV_BITS'(1) : r_scale_divider;

    // ------------------------------------------------------------------
    // datapath chain, held as a whole while the skid register is full
    // ------------------------------------------------------------------
    assign w_en     = !r_skid_valid;
    assign s_tready = w_en;

    cse_extract #(
        .FIELD_BITS(MAX_FIELD_BITS)
    ) u_extract (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (s_tvalid),
        .i_payload      (s_tdata[63:0]),
        .i_byte_count   (s_tdata[67:64]),
        .i_start_bit    (r_start_bit),
        .i_field_length (r_field_length),
        .i_big_endian   (r_big_endian),
        .o_valid        (w_ext_valid),
        .o_err          (w_ext_err),
        .o_raw          (w_ext_raw)
    );

    cse_mul #(
        .FIELD_BITS(MAX_FIELD_BITS)
    ) u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_ext_valid),
        .i_err        (w_ext_err),
        .i_raw        (w_ext_raw),
        .i_multiplier (r_scale_multiplier),
        .i_offset     (r_raw_offset),
        .o_valid      (w_valid[0]),
        .o_meta       (w_meta[0]),
        .o_raw        (w_raw[0]),
        .o_prod       (w_dq[0])
    );

    assign w_rem[0] = '0;

    for (genvar g = 0; g < PROD_BITS; g++) begin : g_cell
        cse_div_cell #(
            .RAW_BITS  (MAX_FIELD_BITS),
            .PROD_BITS (PROD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_div),
            .i_valid (w_valid[g]),
            .i_meta  (w_meta[g]),
            .i_raw   (w_raw[g]),
            .i_rem   (w_rem[g]),
            .i_dq    (w_dq[g]),
            .o_valid (w_valid[g+1]),
            .o_meta  (w_meta[g+1]),
            .o_raw   (w_raw[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_dq    (w_dq[g+1])
        );
    end

    // ------------------------------------------------------------------
    // saturate, apply sign, output register with skid
    // ------------------------------------------------------------------
    assign w_push = w_en && w_valid[PROD_BITS];

    always_comb begin
        n_q   = EXT_BITS'(w_dq[PROD_BITS]);
        n_lim = EXT_BITS'(1) << (SCALED_BITS - 1);
        if (w_meta[PROD_BITS].neg) begin
            n_mag = (n_q > n_lim) ? n_lim : n_q;
        end else begin
            n_mag = (n_q > (n_lim - EXT_BITS'(1))) ? (n_lim - EXT_BITS'(1)) : n_q;
        end
        n_signed = w_meta[PROD_BITS].neg ? (EXT_BITS'(0) - n_mag) : n_mag;
        n_err    = w_meta[PROD_BITS].err;
        n_scaled = n_err ? '0 : n_signed[SCALED_BITS-1:0];
        n_data   = {7'b0, n_scaled, 32'(w_raw[PROD_BITS])};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_err  <= r_skid_err;
            end else begin
                r_out_data <= n_data;
                r_out_err  <= n_err;
            end
        end else if (w_push) begin
            r_skid_data <= n_data;
            r_skid_err  <= n_err;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_err;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("range error result carries nonzero data");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[PROD_BITS] |-> (w_rem[PROD_BITS] < w_div))
        else $error("divider remainder not below divisor");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !m_tready) |=> (r_skid_valid && $stable(r_skid_data)))
        else $error("skid register changed while output stalled");
`endif

endmodule
